// ===== rtl/activity_max_heap_macros.svh =====
// Assertion macros used by the checker of this block
`ifndef ACTIVITY_MAX_HEAP_MACROS_SVH
`define ACTIVITY_MAX_HEAP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AMH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AMH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/amh_pkg.sv =====
package amh_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;
	localparam int SCORE_W  = 32;
	localparam int FUNC_W   = 2;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [SCORE_W-1:0] TOP_SCORE = {1'b1, {(SCORE_W-1){1'b0}}};

	// input function codes
	localparam logic [FUNC_W-1:0] FUNC_POP     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_BUMP    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DECAY   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_RESTORE = 2'd3;

	// register index of num_elements
	localparam logic [ADDR_W-3:0] REG_NUM_ELEMENTS = '0;

	typedef enum logic [2:0] {
		OP_POP,
		OP_BUMP,
		OP_DECAY,
		OP_RESTORE,
		OP_NOP
	} op_t;

	// classified command in the queue between front and engine
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] element;
		logic [CNT_W-1:0] req;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] top_element;
		logic             empty_res;
		logic [CNT_W-1:0] valid_count;
	} res_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POP0,
		ST_POP1,
		ST_POP2,
		ST_POP3,
		ST_SINK0,
		ST_SINK1,
		ST_SINK2,
		ST_RL,
		ST_RR,
		ST_SR,
		ST_CMP,
		ST_SW,
		ST_REST,
		ST_BUMP0,
		ST_BUMP1,
		ST_BUMPW,
		ST_HALVE,
		ST_UP0,
		ST_UP1,
		ST_UP2,
		ST_UP3,
		ST_DONE
	} st_t;

	// halve with rounding up, no overflow
	function automatic logic [SCORE_W-1:0] halve(input logic [SCORE_W-1:0] s);
		return (s >> 1) + {{(SCORE_W-1){1'b0}}, s[0]};
	endfunction

endpackage

// ===== rtl/amh_if.sv =====
interface amh_in_if;
	import amh_pkg::*;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [IDX_W-1:0]    element;
	logic [CNT_W-1:0]    restore_count;
	modport source(output valid, func, element, restore_count, input ready);
	modport sink(input valid, func, element, restore_count, output ready);
endinterface

interface amh_out_if;
	import amh_pkg::*;
	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    top_element;
	logic                empty_res;
	logic [CNT_W-1:0]    valid_count;
	modport source(output valid, top_element, empty_res, valid_count, input ready);
	modport sink(input valid, top_element, empty_res, valid_count, output ready);
endinterface

// ===== rtl/amh_front.sv =====
module amh_front (
	input  logic                    clk,
	input  logic                    arst_n,
	amh_in_if.sink                  in_ch,
	input  logic [amh_pkg::CNT_W-1:0] num_elements,
	input  logic                    hold,
	output logic                    cmd_valid,
	input  logic                    cmd_ready,
	output amh_pkg::cmd_t           cmd
);
	import amh_pkg::*;

	cmd_t       q_mem [2];
	logic       wp_q, rp_q;
	logic [1:0] fill_q;
	cmd_t       cls;
	logic       push, pop;

	// classify the incoming item
	always_comb begin
		cls.element = in_ch.element;
		cls.req     = (in_ch.restore_count > num_elements) ? num_elements
		                                                   : in_ch.restore_count;
		case (in_ch.func)
			FUNC_POP:     cls.op = OP_POP;
			FUNC_BUMP:    cls.op = ({1'b0, in_ch.element} < num_elements) ? OP_BUMP : OP_NOP;
			FUNC_DECAY:   cls.op = OP_DECAY;
			FUNC_RESTORE: cls.op = OP_RESTORE;
			default:      cls.op = OP_NOP;
		endcase
	end

	assign in_ch.ready = (fill_q != 2'd2) && !hold;
	assign push        = in_ch.valid && in_ch.ready;
	assign cmd_valid   = (fill_q != 2'd0);
	assign pop         = cmd_valid && cmd_ready;
	assign cmd         = q_mem[rp_q];

	// two-entry command queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= cls;
	end

endmodule

// ===== rtl/amh_engine.sv =====
module amh_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [amh_pkg::CNT_W-1:0] num_elements,
	input  logic                      cfg_wr,
	output logic                      clearing,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  amh_pkg::cmd_t             cmd,
	output logic                      res_valid,
	input  logic                      res_ready,
	output amh_pkg::res_t             res
);
	import amh_pkg::*;

	// heap stores
	logic [SCORE_W-1:0] score_mem [CAPACITY];
	logic [IDX_W-1:0]   slot_mem  [CAPACITY];
	logic [IDX_W-1:0]   pos_mem   [CAPACITY];

	logic [SCORE_W-1:0] score_rd_q, score_wd;
	logic [IDX_W-1:0]   score_ra, score_wa;
	logic               score_we;
	logic [IDX_W-1:0]   slot_rd_q, slot_ra, slot_wa, slot_wd;
	logic               slot_we;
	logic [IDX_W-1:0]   pos_rd_q, pos_ra, pos_wa, pos_wd;
	logic               pos_we;

	st_t                state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, sw_q, k_q;
	logic               wrap_q, res_valid_q;
	res_t               res_q;
	op_t                op_q;
	logic [IDX_W-1:0]   elem_q, top_q, i_q, c_q, cur_q, el_q, er_q;
	logic               empty_q;
	logic [SCORE_W-1:0] cs_q, sl_q;

	logic [CNT_W:0]     l_w, r_w;
	logic               take_l, take_r, moved, up_stop, res_load;
	logic [SCORE_W-1:0] best;
	logic [IDX_W-1:0]   c_idx, ec, p_idx;

	always_ff @(posedge clk) begin
		if (score_we) score_mem[score_wa] <= score_wd;
		score_rd_q <= score_mem[score_ra];
	end
	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd_q <= slot_mem[slot_ra];
	end
	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		pos_rd_q <= pos_mem[pos_ra];
	end

	// sift-down compare against both children
	always_comb begin
		l_w    = {1'b0, i_q, 1'b1};
		r_w    = l_w + 1'b1;
		take_l = (l_w < {1'b0, cnt_q}) && !(cs_q > sl_q);
		best   = take_l ? sl_q : cs_q;
		take_r = (r_w < {1'b0, cnt_q}) && !(best > score_rd_q);
		moved  = take_l || take_r;
		c_idx  = take_r ? r_w[IDX_W-1:0] : l_w[IDX_W-1:0];
		ec     = take_r ? er_q : el_q;
	end

	// sift-up parent
	assign p_idx    = IDX_W'(i_q - 1'b1) >> 1;
	assign up_stop  = (i_q == '0) || ({1'b0, i_q} >= cnt_q);
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || res_ready);

	assign clearing  = (state_q == ST_CLEAR);
	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sw_q[IDX_W-1:0] == IDX_W'(CAPACITY-1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_POP:     state_d = (cnt_q == '0) ? ST_DONE : ST_POP0;
						OP_BUMP:    state_d = ST_BUMP0;
						OP_DECAY:   state_d = ST_HALVE;
						OP_RESTORE: state_d = (cmd.req >= cnt_q) ? ST_REST : ST_DONE;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_POP0:  state_d = ST_POP1;
			ST_POP1:  state_d = ST_POP2;
			ST_POP2:  state_d = ST_POP3;
			ST_POP3:  state_d = ST_RL;
			ST_SINK0: state_d = ST_SINK1;
			ST_SINK1: state_d = ST_SINK2;
			ST_SINK2: state_d = ST_RL;
			ST_RL:    state_d = ST_RR;
			ST_RR:    state_d = ST_SR;
			ST_SR:    state_d = ST_CMP;
			ST_CMP: begin
				if (moved) state_d = ST_SW;
				else state_d = (op_q == OP_POP) ? ST_DONE : ST_REST;
			end
			ST_SW:    state_d = ST_RL;
			ST_REST:  state_d = (k_q == '0) ? ST_DONE : ST_SINK0;
			ST_BUMP0: state_d = ST_BUMP1;
			ST_BUMP1: state_d = (score_rd_q == '1) ? ST_HALVE : ST_UP0;
			ST_HALVE: begin
				if (sw_q == CNT_W'(CAPACITY)) state_d = wrap_q ? ST_BUMPW : ST_DONE;
			end
			ST_BUMPW: state_d = ST_UP0;
			ST_UP0:   state_d = up_stop ? ST_DONE : ST_UP1;
			ST_UP1:   state_d = ST_UP2;
			ST_UP2:   state_d = (score_rd_q > cs_q) ? ST_DONE : ST_UP3;
			ST_UP3:   state_d = ST_UP0;
			ST_DONE:  if (res_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
		if (cfg_wr) state_d = ST_CLEAR;
	end

	// memory port control
	always_comb begin
		score_ra = '0; score_we = 1'b0; score_wa = '0; score_wd = '0;
		slot_ra  = '0; slot_we  = 1'b0; slot_wa  = '0; slot_wd  = '0;
		pos_ra   = '0; pos_we   = 1'b0; pos_wa   = '0; pos_wd   = '0;
		case (state_q)
			ST_CLEAR: begin
				score_we = 1'b1; score_wa = sw_q[IDX_W-1:0];
				slot_we  = 1'b1; slot_wa  = sw_q[IDX_W-1:0]; slot_wd = sw_q[IDX_W-1:0];
				pos_we   = 1'b1; pos_wa   = sw_q[IDX_W-1:0]; pos_wd  = sw_q[IDX_W-1:0];
			end
			ST_POP0: slot_ra = '0;
			ST_POP1: slot_ra = IDX_W'(cnt_q - 1'b1);
			ST_POP2: begin
				score_ra = slot_rd_q;
				slot_we  = 1'b1; slot_wa = '0;    slot_wd = slot_rd_q;
				pos_we   = 1'b1; pos_wa  = top_q; pos_wd  = cnt_q[IDX_W-1:0];
			end
			ST_POP3: begin
				slot_we = 1'b1; slot_wa = cnt_q[IDX_W-1:0]; slot_wd = top_q;
				pos_we  = 1'b1; pos_wa  = cur_q;            pos_wd  = '0;
			end
			ST_SINK0: slot_ra  = i_q;
			ST_SINK1: score_ra = slot_rd_q;
			ST_RL:    slot_ra  = l_w[IDX_W-1:0];
			ST_RR: begin
				slot_ra  = r_w[IDX_W-1:0];
				score_ra = slot_rd_q;
			end
			ST_SR:    score_ra = slot_rd_q;
			ST_CMP: begin
				if (moved) begin
					slot_we = 1'b1; slot_wa = i_q; slot_wd = ec;
					pos_we  = 1'b1; pos_wa  = ec;  pos_wd  = i_q;
				end
			end
			ST_SW: begin
				slot_we = 1'b1; slot_wa = c_q;   slot_wd = cur_q;
				pos_we  = 1'b1; pos_wa  = cur_q; pos_wd  = c_q;
			end
			ST_BUMP0: begin
				score_ra = elem_q;
				pos_ra   = elem_q;
			end
			ST_BUMP1: begin
				if (score_rd_q != '1) begin
					score_we = 1'b1; score_wa = elem_q; score_wd = score_rd_q + 1'b1;
				end
			end
			ST_HALVE: begin
				score_ra = sw_q[IDX_W-1:0];
				if (sw_q != '0) begin
					score_we = 1'b1;
					score_wa = IDX_W'(sw_q - 1'b1);
					score_wd = halve(score_rd_q);
				end
			end
			ST_BUMPW: begin
				score_we = 1'b1; score_wa = elem_q; score_wd = TOP_SCORE;
			end
			ST_UP0: slot_ra  = p_idx;
			ST_UP1: score_ra = slot_rd_q;
			ST_UP2: begin
				if (!(score_rd_q > cs_q)) begin
					slot_we = 1'b1; slot_wa = p_idx; slot_wd = cur_q;
					pos_we  = 1'b1; pos_wa  = el_q;  pos_wd  = i_q;
				end
			end
			ST_UP3: begin
				slot_we = 1'b1; slot_wa = i_q;   slot_wd = el_q;
				pos_we  = 1'b1; pos_wa  = cur_q; pos_wd  = p_idx;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sw_q        <= '0;
			cnt_q       <= CNT_W'(CAPACITY);
			k_q         <= '0;
			wrap_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) sw_q <= '0;
			else if (state_q == ST_CLEAR || state_q == ST_HALVE) sw_q <= sw_q + 1'b1;
			else sw_q <= '0;
			if (res_load) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: if (state_d == ST_IDLE) cnt_q <= num_elements;
				ST_IDLE: begin
					wrap_q <= 1'b0;
					if (cmd_valid && cmd.op == OP_RESTORE && cmd.req >= cnt_q) begin
						cnt_q <= cmd.req;
						k_q   <= cmd.req >> 1;
					end
				end
				ST_POP1:  cnt_q  <= cnt_q - 1'b1;
				ST_REST:  if (k_q != '0) k_q <= k_q - 1'b1;
				ST_BUMP1: wrap_q <= (score_rd_q == '1);
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.top_element <= top_q;
			res_q.empty_res   <= empty_q;
			res_q.valid_count <= cnt_q;
		end
		case (state_q)
			ST_IDLE: begin
				op_q    <= cmd.op;
				elem_q  <= cmd.element;
				top_q   <= '0;
				empty_q <= (cmd.op == OP_POP) && (cnt_q == '0);
			end
			ST_POP1:  top_q <= slot_rd_q;
			ST_POP2:  cur_q <= slot_rd_q;
			ST_POP3: begin
				cs_q <= score_rd_q;
				i_q  <= '0;
			end
			ST_SINK1: cur_q <= slot_rd_q;
			ST_SINK2: cs_q  <= score_rd_q;
			ST_RR:    el_q  <= slot_rd_q;
			ST_SR: begin
				er_q <= slot_rd_q;
				sl_q <= score_rd_q;
			end
			ST_CMP:   c_q <= c_idx;
			ST_SW:    i_q <= c_q;
			ST_REST:  i_q <= IDX_W'(k_q - 1'b1);
			ST_BUMP1: begin
				i_q   <= pos_rd_q;
				cur_q <= elem_q;
				cs_q  <= score_rd_q + 1'b1;
			end
			ST_BUMPW: cs_q <= TOP_SCORE;
			ST_UP1:   el_q <= slot_rd_q;
			ST_UP3:   i_q  <= p_idx;
			default: ;
		endcase
	end

endmodule

// ===== rtl/activity_max_heap.sv =====
// channel   dir  transfer when        payload
// in_ch     in   valid & ready        func, element, restore_count
// out_ch    out  valid & ready        top_element, empty_res, valid_count
// apb       in   psel&penable&pwrite  num_elements at byte address 0
//
// One item at a time in the engine; a two-entry queue and an output register
// decouple it from the channels. Pop and bump run a sift loop over score, slot and
// position memories, each with one read and one write port; decay walks all
// the scores, and restore, when it does not shrink the heap, runs one sift-down per
// interior slot. After reset and each num_elements write a clearing pass
// runs over the whole store, with in_ch.ready low.
module activity_max_heap (
	input  logic                       clk,
	input  logic                       arst_n,
	amh_in_if.sink                     in_ch,
	amh_out_if.source                  out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [amh_pkg::ADDR_W-1:0] paddr,
	input  logic [amh_pkg::DATA_W-1:0] pwdata,
	output logic [amh_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import amh_pkg::*;

	logic [CNT_W-1:0] num_q, wval;
	logic             cfg_wr, clearing, cmd_valid, cmd_ready, res_valid;
	cmd_t             cmd;
	res_t             res;

	assign pready = 1'b1;
	assign prdata = DATA_W'(num_q);
	assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_NUM_ELEMENTS);

	// clamp written count into 1..CAPACITY
	always_comb begin
		wval = pwdata[CNT_W-1:0];
		if (wval == '0) wval = CNT_W'(1);
		else if (wval > CNT_W'(CAPACITY)) wval = CNT_W'(CAPACITY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_q <= CNT_W'(CAPACITY);
		else if (cfg_wr) num_q <= wval;
	end

	amh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.num_elements (num_q),
		.hold         (clearing),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd)
	);

	amh_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.num_elements (num_q),
		.cfg_wr       (cfg_wr),
		.clearing     (clearing),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.res_valid    (res_valid),
		.res_ready    (out_ch.ready),
		.res          (res)
	);

	assign out_ch.valid       = res_valid;
	assign out_ch.top_element = res.top_element;
	assign out_ch.empty_res   = res.empty_res;
	assign out_ch.valid_count = res.valid_count;

endmodule

// ===== rtl/amh_checker.sv =====
`include "activity_max_heap_macros.svh"

module amh_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [amh_pkg::IDX_W-1:0]  out_top_element,
	input logic                       out_empty_res,
	input logic [amh_pkg::CNT_W-1:0]  out_valid_count,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [amh_pkg::ADDR_W-1:0] paddr
);
	import amh_pkg::*;

	// a stalled result stays put
	`AMH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_valid_count), "result dropped while stalled")
	// an empty pop reports no element and an empty heap
	`AMH_ASSERT_IMP(a_empty, out_valid && out_empty_res, out_top_element == '0 && out_valid_count == '0, "empty pop with element or count")
	// count never exceeds the store
	`AMH_ASSERT_IMP(a_count, out_valid, out_valid_count <= CNT_W'(CAPACITY), "count beyond capacity")
	// a count write starts the clearing pass
	`AMH_ASSERT_NXT(a_clear, psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_NUM_ELEMENTS, !in_ready, "input open after count write")

endmodule

bind activity_max_heap amh_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_top_element (out_ch.top_element),
	.out_empty_res   (out_ch.empty_res),
	.out_valid_count (out_ch.valid_count),
	.psel            (psel),
	.penable         (penable),
	.pwrite          (pwrite),
	.paddr           (paddr)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import amh_pkg::*;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  element;
		logic [CNT_W-1:0]  restore_count;
	} heap_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	amh_in_if  in_ch();
	amh_out_if out_ch();

	activity_max_heap dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow heap state
	logic [SCORE_W-1:0] act_score [CAPACITY];
	int unsigned        slot_elem [CAPACITY];
	int unsigned        elem_slot [CAPACITY];
	int unsigned        live_count;
	int unsigned        elems_in_use;

	heap_cmd_t pending_cmds[$];
	res_t      due_results[$];
	int        mismatches = 0;
	int        results_seen = 0;
	int        pops_empty = 0;
	bit        idling_on = 1'b1;
	int        hold_off = 0;
	int        in_gap = 0;
	int        out_gap = 0;
	bit        in_fire = 1'b0;

	function automatic bit outranks(int unsigned p, int unsigned q);
		return act_score[slot_elem[p]] > act_score[slot_elem[q]];
	endfunction

	function automatic void swap_slots(int unsigned p, int unsigned q);
		int unsigned ep, eq;
		ep = slot_elem[p];
		eq = slot_elem[q];
		slot_elem[p] = eq;
		slot_elem[q] = ep;
		elem_slot[ep] = q;
		elem_slot[eq] = p;
	endfunction

	function automatic void sink_slot(int unsigned i);
		int unsigned c;
		forever begin
			c = i;
			if (2*i+1 < live_count && !outranks(c, 2*i+1)) c = 2*i+1;
			if (2*i+2 < live_count && !outranks(c, 2*i+2)) c = 2*i+2;
			if (c == i) break;
			swap_slots(i, c);
			i = c;
		end
	endfunction

	function automatic void sift_up(int unsigned i);
		int unsigned p;
		while (i != 0 && i < live_count) begin
			p = (i - 1) / 2;
			if (outranks(p, i)) break;
			swap_slots(p, i);
			i = p;
		end
	endfunction

	function automatic void halve_scores();
		for (int k = 0; k < CAPACITY; k++)
			act_score[k] = (act_score[k] >> 1) + act_score[k][0];
	endfunction

	function automatic void set_elements(logic [DATA_W-1:0] value);
		int unsigned v;
		v = 32'(value[CNT_W-1:0]);
		if (v < 1) v = 1;
		if (v > CAPACITY) v = CAPACITY;
		elems_in_use = v;
		for (int k = 0; k < CAPACITY; k++) begin
			act_score[k] = '0;
			slot_elem[k] = k;
			elem_slot[k] = k;
		end
		live_count = v;
	endfunction

	// apply one command to the shadow heap and give the result it produces
	function automatic res_t heap_apply(heap_cmd_t c);
		res_t r;
		int unsigned want;
		r = '0;
		case (c.func)
			FUNC_POP: begin
				if (live_count == 0) begin
					r.empty_res = 1'b1;
				end else begin
					r.top_element = IDX_W'(slot_elem[0]);
					live_count--;
					swap_slots(0, live_count);
					sink_slot(0);
				end
			end
			FUNC_BUMP: begin
				if (c.element < elems_in_use) begin
					act_score[c.element] = act_score[c.element] + 1;
					if (act_score[c.element] == '0) begin
						halve_scores();
						act_score[c.element] = TOP_SCORE;
					end
					if (elem_slot[c.element] < live_count)
						sift_up(elem_slot[c.element]);
				end
			end
			FUNC_DECAY: halve_scores();
			default: begin
				want = 32'(c.restore_count);
				if (want > elems_in_use) want = elems_in_use;
				if (want >= live_count) begin
					live_count = want;
					for (int k = live_count / 2; k != 0; k--)
						sink_slot(k - 1);
				end
			end
		endcase
		r.valid_count = CNT_W'(live_count);
		return r;
	endfunction

	function automatic int pick_gap();
		int d;
		d = $urandom_range(0, 99);
		if (d < 60) return 0;
		if (d < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// sender: a new command goes out once the previous one has transferred
	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || in_fire)) begin
			if (in_gap > 0) begin
				in_ch.valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_cmds.size() > 0) begin
				heap_cmd_t c;
				c = pending_cmds.pop_front();
				in_ch.valid         <= 1'b1;
				in_ch.func          <= c.func;
				in_ch.element       <= c.element;
				in_ch.restore_count <= c.restore_count;
				if (idling_on) in_gap <= pick_gap();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: long hold-off first, then random stalls
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ch.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else if (out_gap > 0) begin
			out_ch.ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else begin
			out_ch.ready <= 1'b1;
			if (idling_on && $urandom_range(0, 7) == 0) out_gap <= pick_gap();
		end
	end

	// input transfers feed the predictor
	always @(posedge clk) begin
		in_fire <= in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			heap_cmd_t c;
			res_t      r;
			c.func = in_ch.func;
			c.element = in_ch.element;
			c.restore_count = in_ch.restore_count;
			r = heap_apply(c);
			due_results.insert(due_results.size(), r);
		end
	end

	// output transfers checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			res_t want;
			results_seen++;
			if (out_ch.empty_res) pops_empty++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result top=%0d empty=%0d count=%0d",
						out_ch.top_element, out_ch.empty_res, out_ch.valid_count);
			end else begin
				want = due_results.pop_front();
				if (out_ch.top_element !== want.top_element ||
					out_ch.empty_res !== want.empty_res ||
					out_ch.valid_count !== want.valid_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: top %0d/%0d empty %0d/%0d count %0d/%0d (exp/act)",
							want.top_element, out_ch.top_element,
							want.empty_res, out_ch.empty_res,
							want.valid_count, out_ch.valid_count);
				end
			end
		end
	end

	task automatic reg_write(logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {REG_NUM_ELEMENTS, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		set_elements(value);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic push_cmd(logic [FUNC_W-1:0] f, int unsigned e, int unsigned rc);
		heap_cmd_t c;
		c.func = f;
		c.element = IDX_W'(e);
		c.restore_count = CNT_W'(rc);
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	// wait until everything queued has transferred and every result is back
	task automatic drain();
		while (pending_cmds.size() > 0 || in_ch.valid || due_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// random mix; full-size heaps get few of the store-wide operations
	task automatic random_cmds(int count, bit full_size);
		int d;
		for (int k = 0; k < count; k++) begin
			d = $urandom_range(0, 99);
			if (d < 35)
				push_cmd(FUNC_POP, $urandom_range(0, CAPACITY-1), $urandom_range(0, CAPACITY));
			else if (d < 80)
				push_cmd(FUNC_BUMP, ($urandom_range(0, 9) == 0) ?
					$urandom_range(0, CAPACITY-1) : $urandom_range(0, elems_in_use-1),
					$urandom_range(0, CAPACITY));
			else if (d < (full_size ? 83 : 90))
				push_cmd(FUNC_DECAY, $urandom_range(0, CAPACITY-1), $urandom_range(0, CAPACITY));
			else if (full_size && d < 99)
				push_cmd(FUNC_POP, 0, 0);
			else
				push_cmd(FUNC_RESTORE, $urandom_range(0, CAPACITY-1),
					($urandom_range(0, 1) == 0) ? elems_in_use : $urandom_range(0, CAPACITY));
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_POP;
		in_ch.element = '0;
		in_ch.restore_count = '0;
		out_ch.ready = 1'b0;
		set_elements(CAPACITY);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset-size heap, extremes and the quiet cases
		push_cmd(FUNC_POP, 0, 0);
		push_cmd(FUNC_BUMP, CAPACITY-1, 0);
		push_cmd(FUNC_BUMP, 0, CAPACITY);
		push_cmd(FUNC_BUMP, CAPACITY-1, 0);
		push_cmd(FUNC_POP, 0, 0);
		push_cmd(FUNC_DECAY, 0, 0);
		push_cmd(FUNC_BUMP, 0, 0);
		push_cmd(FUNC_RESTORE, 0, 0);
		push_cmd(FUNC_RESTORE, CAPACITY-1, CAPACITY);
		push_cmd(FUNC_POP, 0, 0);
		drain();

		// single element: empty pops, unused bumps, clamped restore
		reg_write(32'd0);
		push_cmd(FUNC_POP, 0, 0);
		push_cmd(FUNC_POP, 0, 0);
		push_cmd(FUNC_BUMP, 5, 0);
		push_cmd(FUNC_BUMP, 0, 0);
		push_cmd(FUNC_RESTORE, 0, CAPACITY);
		push_cmd(FUNC_POP, 0, 0);
		push_cmd(FUNC_RESTORE, 0, 0);
		push_cmd(FUNC_DECAY, 0, 0);
		drain();
		random_cmds(40, 1'b0);
		drain();

		// small heap with the receiver held off while the sender keeps offering
		reg_write(32'd5);
		hold_off = 400;
		random_cmds(120, 1'b0);
		drain();

		// upper bits of the write data are ignored: sixteen elements, no idling
		reg_write(32'hFFFF_F810);
		idling_on = 1'b0;
		random_cmds(120, 1'b0);
		drain();
		idling_on = 1'b1;

		reg_write(32'd63);
		random_cmds(120, 1'b0);
		drain();

		// oversize write clamps to full capacity
		reg_write(32'h0000_07FF);
		random_cmds(60, 1'b1);
		drain();

		reg_write(32'd1024);
		random_cmds(80, 1'b0);
		drain();

		$display("covered %0d results (%0d empty pops) across five element counts",
			results_seen, pops_empty);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout with %0d results outstanding", due_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/amh_pkg.sv
rtl/amh_if.sv
rtl/amh_front.sv
rtl/amh_engine.sv
rtl/activity_max_heap.sv
rtl/amh_checker.sv
tb/testbench.sv
